// ===== rtl/rotary_axis_step_detector_defines.svh =====
// Assertion macros for the rotary axis step detector RTL.
`ifndef ROTARY_AXIS_STEP_DETECTOR_DEFINES_SVH
`define ROTARY_AXIS_STEP_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define RASD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define RASD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RASD_ASSERT_SAME(lbl, ante, cons, msg)
`define RASD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/rasd_pkg.sv =====
// Types, constants and helper functions of the rotary axis step detector.
`default_nettype none
package rasd_pkg;

	localparam int NUM_AXES   = 9;
	localparam int NUM_SHIFT  = 2;
	localparam int NUM_MODES  = 3;
	localparam int NUM_BANDS  = 15;
	localparam int FULL_SCALE = 2048;

	localparam int PROFILES = NUM_SHIFT * NUM_MODES * NUM_AXES;
	localparam int SLOTS    = PROFILES * NUM_BANDS;

	localparam int CMD_W    = 2;
	localparam int SHIFT_W  = 1;
	localparam int MODE_W   = 2;
	localparam int AXIS_W   = 4;
	localparam int POS_W    = 11;
	localparam int BAND_W   = 4;
	localparam int LIMIT_W  = 8;
	localparam int ACTION_W = 16;
	localparam int KIND_W   = 2;
	localparam int RESIST_W = 8;

	localparam int PROF_W      = $clog2(PROFILES);
	localparam int SLOT_ADDR_W = $clog2(SLOTS);

	// Percent value that closes the band list.
	localparam int PCT_FULL = 100;
	localparam int TOP_W    = $clog2(FULL_SCALE + 1);
	localparam int CMP_W    = ((POS_W > TOP_W) ? POS_W : TOP_W) + 1;

	localparam int KIND_INCR_BIT = 0;
	localparam int KIND_BAND_BIT = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_SETTINGS = 2'd1,
		CMD_LIMIT    = 2'd2,
		CMD_ACTION   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_EVAL,
		ST_WALK,
		ST_ACT
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [SHIFT_W-1:0]  shift_level;
		logic [MODE_W-1:0]   mode_sel;
		logic [AXIS_W-1:0]   axis;
		logic [POS_W-1:0]    position;
		logic [BAND_W-1:0]   slot;
		logic [LIMIT_W-1:0]  band_limit;
		logic [ACTION_W-1:0] action_value;
		logic [KIND_W-1:0]   axis_kind;
		logic [RESIST_W-1:0] resist_up;
		logic [RESIST_W-1:0] resist_down;
	} in_item_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action_id;
		logic [BAND_W-1:0]   change_index;
		logic [AXIS_W-1:0]   axis_echo;
		logic [SHIFT_W-1:0]  shift_echo;
		logic [MODE_W-1:0]   mode_echo;
		logic [POS_W-1:0]    incremental_position;
		logic [BAND_W-1:0]   band_index;
	} out_item_t;

	// One entry per profile: settings plus the tracking state.
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [RESIST_W-1:0] up;
		logic [RESIST_W-1:0] down;
		logic [POS_W-1:0]    last_pos;
		logic [BAND_W-1:0]   last_band;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic prof_ok(input logic [SHIFT_W-1:0] sh,
		input logic [MODE_W-1:0] md, input logic [AXIS_W-1:0] ax);
		return (int'(sh) < NUM_SHIFT) && (int'(md) < NUM_MODES) && (int'(ax) < NUM_AXES);
	endfunction

	function automatic logic [PROF_W-1:0] prof_index(input logic [SHIFT_W-1:0] sh,
		input logic [MODE_W-1:0] md, input logic [AXIS_W-1:0] ax);
		return PROF_W'((int'(sh) * NUM_MODES + int'(md)) * NUM_AXES + int'(ax));
	endfunction

	function automatic logic [SLOT_ADDR_W-1:0] slot_base(input logic [PROF_W-1:0] p);
		return SLOT_ADDR_W'(int'(p) * NUM_BANDS);
	endfunction

	// Constant table: upper position bound of a band for a percent limit.
	function automatic logic [TOP_W-1:0] band_top(input logic [LIMIT_W-1:0] lim);
		logic [TOP_W-1:0] r;
		r = '0;
		for (int i = 0; i <= PCT_FULL; i++) begin
			if (lim == LIMIT_W'(i)) begin
				r = TOP_W'((i * FULL_SCALE) / PCT_FULL);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rasd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rasd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rasd_core.sv =====
// Sequencer of the step detector: profile memory, band walk and action lookup.
`default_nettype none
`include "rotary_axis_step_detector_defines.svh"
module rasd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  rasd_pkg::in_item_t  cmd_data,
	output logic                res_valid,
	output rasd_pkg::out_item_t res_data,
	input  logic                res_take
);

	rasd_pkg::state_t state_q, state_d;
	logic [rasd_pkg::SLOT_ADDR_W-1:0] clr_q;

	rasd_pkg::in_item_t               item_q;
	logic [rasd_pkg::PROF_W-1:0]      p_q;
	logic [rasd_pkg::SLOT_ADDR_W-1:0] base_q;
	rasd_pkg::entry_t                 entry_q;
	logic [rasd_pkg::BAND_W-1:0]      idx_q;
	logic [rasd_pkg::TOP_W-1:0]       prev_q;
	logic [rasd_pkg::BAND_W-1:0]      fired_q;
	logic [rasd_pkg::POS_W-1:0]       res_pos_q;
	logic [rasd_pkg::BAND_W-1:0]      res_band_q;

	logic                             entry_we, entry_re;
	logic [rasd_pkg::PROF_W-1:0]      entry_waddr;
	rasd_pkg::entry_t                 entry_wdata, entry_rdata;

	logic                             band_we, band_re;
	logic [rasd_pkg::SLOT_ADDR_W-1:0] band_waddr, band_raddr;
	logic [rasd_pkg::LIMIT_W-1:0]     band_wdata, band_rdata;

	logic                             act_we, act_re;
	logic [rasd_pkg::SLOT_ADDR_W-1:0] act_waddr, act_raddr;
	logic [rasd_pkg::ACTION_W-1:0]    act_rdata;

	logic                             slot_ok;
	logic [rasd_pkg::BAND_W-1:0]      fire_slot;
	logic [rasd_pkg::CMP_W-1:0]       pos_x, old_x, up_x, dn_x, top_x;
	logic                             move_up, up_fire, dn_fire;
	logic                             lim_end, hit, walk_end;
	logic [rasd_pkg::TOP_W-1:0]       top_w;

	logic                             act_enter, clr_last, in_act, in_walk;

	rasd_ram #(.WIDTH(rasd_pkg::ENTRY_W), .DEPTH(rasd_pkg::PROFILES)) u_entry_ram (
		.clk   (clk),
		.we    (entry_we),
		.waddr (entry_waddr),
		.wdata (entry_wdata),
		.re    (entry_re),
		.raddr (p_q),
		.rdata (entry_rdata)
	);

	rasd_ram #(.WIDTH(rasd_pkg::LIMIT_W), .DEPTH(rasd_pkg::SLOTS)) u_band_ram (
		.clk   (clk),
		.we    (band_we),
		.waddr (band_waddr),
		.wdata (band_wdata),
		.re    (band_re),
		.raddr (band_raddr),
		.rdata (band_rdata)
	);

	rasd_ram #(.WIDTH(rasd_pkg::ACTION_W), .DEPTH(rasd_pkg::SLOTS)) u_action_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (item_q.action_value),
		.re    (act_re),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	// Step tests of the incremental profile, on the entry just read.
	always_comb begin
		pos_x   = rasd_pkg::CMP_W'(item_q.position);
		old_x   = rasd_pkg::CMP_W'(entry_rdata.last_pos);
		up_x    = rasd_pkg::CMP_W'(entry_rdata.up);
		dn_x    = rasd_pkg::CMP_W'(entry_rdata.down);
		move_up = pos_x > old_x;
		up_fire = move_up && (old_x < rasd_pkg::CMP_W'(rasd_pkg::FULL_SCALE) - up_x)
			&& (pos_x > old_x + up_x);
		dn_fire = !move_up && (old_x > dn_x) && (pos_x < old_x - dn_x);
	end

	// One band of the walk per cycle: the limit read last cycle is checked here.
	always_comb begin
		lim_end  = (band_rdata == '0) ||
			(band_rdata >= rasd_pkg::LIMIT_W'(rasd_pkg::PCT_FULL));
		top_w    = rasd_pkg::band_top(lim_end ?
			rasd_pkg::LIMIT_W'(rasd_pkg::PCT_FULL) : band_rdata);
		top_x    = rasd_pkg::CMP_W'(top_w);
		hit      = (pos_x >= rasd_pkg::CMP_W'(prev_q)) && (pos_x < top_x);
		walk_end = lim_end || (idx_q == rasd_pkg::BAND_W'(rasd_pkg::NUM_BANDS - 1));
	end

	assign slot_ok   = int'(item_q.slot) < rasd_pkg::NUM_BANDS;
	assign act_waddr = base_q + rasd_pkg::SLOT_ADDR_W'(item_q.slot);
	assign act_raddr = base_q + rasd_pkg::SLOT_ADDR_W'(fire_slot);

	always_comb begin
		state_d     = state_q;
		cmd_ready   = 1'b0;
		res_valid   = 1'b0;
		entry_we    = 1'b0;
		entry_re    = 1'b0;
		entry_waddr = p_q;
		entry_wdata = entry_rdata;
		band_we     = 1'b0;
		band_re     = 1'b0;
		band_waddr  = base_q + rasd_pkg::SLOT_ADDR_W'(item_q.slot);
		band_wdata  = item_q.band_limit;
		band_raddr  = base_q;
		act_we      = 1'b0;
		act_re      = 1'b0;
		fire_slot   = idx_q;
		case (state_q)
			rasd_pkg::ST_CLEAR: begin
				band_we     = 1'b1;
				band_waddr  = clr_q;
				band_wdata  = '0;
				entry_we    = clr_q < rasd_pkg::SLOT_ADDR_W'(rasd_pkg::PROFILES);
				entry_waddr = clr_q[rasd_pkg::PROF_W-1:0];
				entry_wdata = '0;
				if (clr_q == rasd_pkg::SLOT_ADDR_W'(rasd_pkg::SLOTS - 1)) begin
					state_d = rasd_pkg::ST_IDLE;
				end
			end
			rasd_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && rasd_pkg::prof_ok(cmd_data.shift_level, cmd_data.mode_sel,
					cmd_data.axis)) begin
					state_d = rasd_pkg::ST_DISPATCH;
				end
			end
			rasd_pkg::ST_DISPATCH: begin
				case (item_q.cmd)
					rasd_pkg::CMD_LIMIT: begin
						band_we = slot_ok;
						state_d = rasd_pkg::ST_IDLE;
					end
					rasd_pkg::CMD_ACTION: begin
						act_we  = slot_ok;
						state_d = rasd_pkg::ST_IDLE;
					end
					default: begin
						entry_re = 1'b1;
						state_d  = rasd_pkg::ST_EVAL;
					end
				endcase
			end
			rasd_pkg::ST_EVAL: begin
				state_d = rasd_pkg::ST_IDLE;
				if (item_q.cmd == rasd_pkg::CMD_SETTINGS) begin
					entry_we         = 1'b1;
					entry_wdata.kind = item_q.axis_kind;
					entry_wdata.up   = item_q.resist_up;
					entry_wdata.down = item_q.resist_down;
				end else if (entry_rdata.kind[rasd_pkg::KIND_INCR_BIT]) begin
					fire_slot = up_fire ? rasd_pkg::BAND_W'(0) : rasd_pkg::BAND_W'(1);
					if (up_fire || dn_fire) begin
						entry_we             = 1'b1;
						entry_wdata.last_pos = item_q.position;
						act_re               = 1'b1;
						state_d              = rasd_pkg::ST_ACT;
					end
				end else if (entry_rdata.kind[rasd_pkg::KIND_BAND_BIT]) begin
					band_re    = 1'b1;
					band_raddr = base_q;
					state_d    = rasd_pkg::ST_WALK;
				end
			end
			rasd_pkg::ST_WALK: begin
				entry_wdata = entry_q;
				if (hit) begin
					state_d = rasd_pkg::ST_IDLE;
					if (idx_q != entry_q.last_band) begin
						entry_we              = 1'b1;
						entry_wdata.last_band = idx_q;
						act_re                = 1'b1;
						state_d               = rasd_pkg::ST_ACT;
					end
				end else if (walk_end) begin
					state_d = rasd_pkg::ST_IDLE;
				end else begin
					band_re    = 1'b1;
					band_raddr = base_q + rasd_pkg::SLOT_ADDR_W'(idx_q)
						+ rasd_pkg::SLOT_ADDR_W'(1);
				end
			end
			rasd_pkg::ST_ACT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = rasd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rasd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rasd_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rasd_pkg::ST_CLEAR) begin
				clr_q <= clr_q + rasd_pkg::SLOT_ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_q <= cmd_data;
			p_q    <= rasd_pkg::prof_index(cmd_data.shift_level, cmd_data.mode_sel, cmd_data.axis);
			base_q <= rasd_pkg::slot_base(rasd_pkg::prof_index(cmd_data.shift_level,
				cmd_data.mode_sel, cmd_data.axis));
		end
		if (state_q == rasd_pkg::ST_EVAL) begin
			entry_q <= entry_rdata;
			idx_q   <= '0;
			prev_q  <= '0;
		end
		if (state_q == rasd_pkg::ST_WALK && !hit) begin
			idx_q  <= idx_q + rasd_pkg::BAND_W'(1);
			prev_q <= top_w;
		end
		if (act_re) begin
			fired_q    <= fire_slot;
			res_pos_q  <= entry_wdata.last_pos;
			res_band_q <= entry_wdata.last_band;
		end
	end

	always_comb begin
		res_data.action_id            = act_rdata;
		res_data.change_index         = fired_q;
		res_data.axis_echo            = item_q.axis;
		res_data.shift_echo           = item_q.shift_level;
		res_data.mode_echo            = item_q.mode_sel;
		res_data.incremental_position = res_pos_q;
		res_data.band_index           = res_band_q;
	end

	assign act_enter = (state_q != rasd_pkg::ST_ACT) && (state_d == rasd_pkg::ST_ACT);
	assign clr_last  = (state_q == rasd_pkg::ST_CLEAR)
		&& (clr_q == rasd_pkg::SLOT_ADDR_W'(rasd_pkg::SLOTS - 1));
	assign in_act    = state_q == rasd_pkg::ST_ACT;
	assign in_walk   = state_q == rasd_pkg::ST_WALK;

	`RASD_ASSERT_SAME(a_fire_updates_entry, act_enter, entry_we && act_re, "fire without write-back")
	`RASD_ASSERT_SAME(a_act_holds_lookup, in_act, !act_re && !act_we, "action memory busy in ACT")
	`RASD_ASSERT_SAME(a_walk_in_range, in_walk, int'(idx_q) < rasd_pkg::NUM_BANDS, "walk overrun")
	`RASD_ASSERT_NEXT(a_clear_ends, clr_last, state_q == rasd_pkg::ST_IDLE, "clearing did not end")

endmodule
`default_nettype wire

// ===== rtl/rotary_axis_step_detector.sv =====
// Top level of the rotary axis step detector: sequencer plus result register.
//
// Usage: the cmd channel (cmd_valid, cmd_ready, cmd_data) carries one item per
// transfer: a position sample, an axis settings write, a band limit write or an
// action id write, each for the profile picked by shift level, mode and axis.
// The evt channel (evt_valid, evt_ready, evt_data) returns one event for each
// sample that moves an incremental axis far enough or moves a banded axis into
// a new band; all other items return nothing. Items with an out-of-range
// profile, or writes to an out-of-range slot, are dropped.
// Items are handled one at a time. A band limit or action id write ends in
// dispatch; a settings write or a sample goes on to read its profile entry.
// A banded sample then walks its limits one band per cycle; a sample that
// fires does an action lookup before its event is offered. After reset the
// block clears its profile and limit memories, one entry per cycle, over
// all 810 limit slots (PROFILES * NUM_BANDS) before cmd_ready first rises.
// Action ids are not cleared and must be written before they can fire.
// The result register lets the next item be taken while an event waits; when
// the receiver holds evt_ready low, a second event waits in the sequencer and
// no further item is taken until the register drains.
`default_nettype none
module rotary_axis_step_detector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  rasd_pkg::in_item_t  cmd_data,
	output logic                evt_valid,
	input  logic                evt_ready,
	output rasd_pkg::out_item_t evt_data
);

	logic                res_valid;
	logic                res_take;
	rasd_pkg::out_item_t res_data;
	logic                evt_valid_q;
	rasd_pkg::out_item_t evt_data_q;

	rasd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_take  (res_take)
	);

	// The register is free when empty or when its event leaves in this cycle.
	assign res_take = res_valid && (!evt_valid_q || evt_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (res_take) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			evt_data_q <= res_data;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt_data  = evt_data_q;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the rotary axis step detector, with directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
	import rasd_pkg::*;

	// The run is a few thousand items, so this limit only trips on a hang.
	localparam int CYCLE_LIMIT   = 1_000_000;
	// Longest sample is a full band walk plus the action lookup and the
	// result register, so this covers anything still in flight at the end.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int HOT_COUNT     = 6;
	localparam int REPORT_LIMIT  = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	in_item_t  cmd_data  = '0;
	logic      evt_valid;
	logic      evt_ready = 1'b0;
	out_item_t evt_data;

	rotary_axis_step_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt_data  (evt_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block's state, one entry per profile (shift, mode,
	// axis), plus the per-profile band limit and action id tables.
	logic [POS_W-1:0]    step_ref   [PROFILES];
	logic [BAND_W-1:0]   band_now   [PROFILES];
	logic [KIND_W-1:0]   prof_kind  [PROFILES];
	logic [RESIST_W-1:0] prof_up    [PROFILES];
	logic [RESIST_W-1:0] prof_down  [PROFILES];
	logic [LIMIT_W-1:0]  limit_mem  [SLOTS];
	logic [ACTION_W-1:0] action_mem [SLOTS];
	bit                  action_loaded [SLOTS];

	// Events the block owes us, oldest first.
	out_item_t pending_events [$];

	int fail_count  = 0;
	int cycle_count = 0;
	// When set, neither side inserts idle cycles, so back-to-back transfers
	// are exercised as well.
	bit quiet_phase = 1'b0;
	int hot_prof [HOT_COUNT];

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_model();
		for (int p = 0; p < PROFILES; p++) begin
			step_ref[p]  = '0;
			band_now[p]  = '0;
			prof_kind[p] = '0;
			prof_up[p]   = '0;
			prof_down[p] = '0;
		end
		for (int s = 0; s < SLOTS; s++) begin
			limit_mem[s]     = '0;
			action_mem[s]    = '0;
			action_loaded[s] = 1'b0;
		end
	endfunction

	// Flat profile number, or -1 when the item names a profile that does not
	// exist and the block drops it.
	function automatic int profile_of(input in_item_t it);
		if (it.shift_level >= NUM_SHIFT || it.mode_sel >= NUM_MODES || it.axis >= NUM_AXES)
			return -1;
		return (int'(it.shift_level) * NUM_MODES + int'(it.mode_sel)) * NUM_AXES
			+ int'(it.axis);
	endfunction

	// Walks the band list of a profile. A limit of zero or of 100 percent and
	// more closes the list; the lower bound of each band is the previous top
	// at full width.
	function automatic int band_of(input int p, input int pos);
		int lower;
		int lim;
		int top;
		lower = 0;
		for (int i = 0; i < NUM_BANDS; i++) begin
			lim = int'(limit_mem[p * NUM_BANDS + i]);
			if (lim == 0 || lim >= PCT_FULL)
				lim = PCT_FULL;
			top = lim * FULL_SCALE / PCT_FULL;
			if (pos >= lower && pos < top)
				return i;
			if (lim == PCT_FULL)
				break;
			lower = top;
		end
		return -1;
	endfunction

	// Slot that a sample would fire, or -1. Leaves the shadow state alone.
	function automatic int fired_slot(input in_item_t it);
		int p;
		int old_pos;
		int pos;
		int up;
		int down;
		int b;
		p = profile_of(it);
		if (p < 0 || it.cmd != CMD_SAMPLE)
			return -1;
		old_pos = int'(step_ref[p]);
		pos     = int'(it.position);
		up      = int'(prof_up[p]);
		down    = int'(prof_down[p]);
		// Incremental mode wins when both mode bits are set.
		if (prof_kind[p][KIND_INCR_BIT]) begin
			if (pos > old_pos) begin
				if (old_pos < FULL_SCALE - up && pos > old_pos + up)
					return 0;
			end else if (old_pos > down && pos < old_pos - down) begin
				return 1;
			end
			return -1;
		end
		if (prof_kind[p][KIND_BAND_BIT]) begin
			b = band_of(p, pos);
			if (b >= 0 && b != int'(band_now[p]))
				return b;
		end
		return -1;
	endfunction

	// Applies one accepted item to the shadow state and queues the event it
	// causes, if any.
	function automatic void predict_event(input in_item_t it);
		int p;
		int idx;
		int slot;
		out_item_t ev;
		p = profile_of(it);
		if (p < 0)
			return;
		idx = p * NUM_BANDS + int'(it.slot);
		if (it.cmd == CMD_SETTINGS) begin
			prof_kind[p] = it.axis_kind;
			prof_up[p]   = it.resist_up;
			prof_down[p] = it.resist_down;
		end else if (it.cmd == CMD_LIMIT) begin
			if (it.slot < NUM_BANDS)
				limit_mem[idx] = it.band_limit;
		end else if (it.cmd == CMD_ACTION) begin
			if (it.slot < NUM_BANDS) begin
				action_mem[idx]    = it.action_value;
				action_loaded[idx] = 1'b1;
			end
		end else begin
			slot = fired_slot(it);
			if (slot >= 0) begin
				if (prof_kind[p][KIND_INCR_BIT])
					step_ref[p] = it.position;
				else
					band_now[p] = BAND_W'(slot);
				ev.action_id            = action_mem[p * NUM_BANDS + slot];
				ev.change_index         = BAND_W'(slot);
				ev.axis_echo            = it.axis;
				ev.shift_echo           = it.shift_level;
				ev.mode_echo            = it.mode_sel;
				ev.incremental_position = step_ref[p];
				ev.band_index           = band_now[p];
				pending_events.push_back(ev);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Every field random, then the command and profile forced. Fields that
	// the command does not use keep their random bits on purpose.
	function automatic in_item_t random_item(input cmd_t c, input int sh, md, ax);
		logic [95:0] raw;
		in_item_t it;
		raw = {$urandom(), $urandom(), $urandom()};
		it = raw[$bits(in_item_t)-1:0];
		it.cmd         = c;
		it.shift_level = SHIFT_W'(sh);
		it.mode_sel    = MODE_W'(md);
		it.axis        = AXIS_W'(ax);
		return it;
	endfunction

	function automatic void split_profile(input int p, output int sh, md, ax);
		ax = p % NUM_AXES;
		md = (p / NUM_AXES) % NUM_MODES;
		sh = p / (NUM_AXES * NUM_MODES);
	endfunction

	// Small resistances make incremental steps frequent; full range covers
	// the edge limits.
	function automatic int resist_draw();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 40);
		return $urandom_range(0, 255);
	endfunction

	// Positions aimed at the interesting spots of a profile: just around the
	// step thresholds and just around a band top, with some uniform ones.
	function automatic int aim_position(input int p);
		int lim;
		case ($urandom_range(0, 3))
			0: begin
				return $urandom_range(0, FULL_SCALE - 1);
			end
			1: begin
				return int'(step_ref[p]) + int'(prof_up[p]) + int'($urandom_range(0, 2));
			end
			2: begin
				return int'(step_ref[p]) - int'(prof_down[p]) - int'($urandom_range(0, 2));
			end
			default: begin
				lim = int'(limit_mem[p * NUM_BANDS + int'($urandom_range(0, NUM_BANDS - 1))]);
				return lim * FULL_SCALE / PCT_FULL + int'($urandom_range(0, 2)) - 1;
			end
		endcase
	endfunction

	// One transfer on the cmd channel. Valid is left high after the transfer
	// so that a following item with no gap is offered at once;
	// any caller that spends time afterwards lowers it first.
	task automatic push_item(input in_item_t it);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_data  <= it;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_ready !== 1'b1);
		predict_event(it);
	endtask

	// Action ids have no reset value, so a sample that is about to fire an
	// unloaded slot gets that slot written first.
	task automatic send_item(input in_item_t it);
		in_item_t load;
		int slot;
		int p;
		slot = fired_slot(it);
		if (slot >= 0) begin
			p = profile_of(it);
			if (!action_loaded[p * NUM_BANDS + slot]) begin
				load = random_item(CMD_ACTION, it.shift_level, it.mode_sel, it.axis);
				load.slot = BAND_W'(slot);
				push_item(load);
			end
		end
		push_item(it);
	endtask

	task automatic send_settings(input int sh, md, ax, kind, up, down);
		in_item_t it;
		it = random_item(CMD_SETTINGS, sh, md, ax);
		it.axis_kind   = KIND_W'(kind);
		it.resist_up   = RESIST_W'(up);
		it.resist_down = RESIST_W'(down);
		send_item(it);
	endtask

	// Band limit or action id write; the value lands in the field the
	// command uses.
	task automatic send_table(input cmd_t c, input int sh, md, ax, slot, value);
		in_item_t it;
		it = random_item(c, sh, md, ax);
		it.slot         = BAND_W'(slot);
		it.band_limit   = LIMIT_W'(value);
		it.action_value = ACTION_W'(value);
		send_item(it);
	endtask

	task automatic sample_at(input int sh, md, ax, pos);
		in_item_t it;
		it = random_item(CMD_SAMPLE, sh, md, ax);
		it.position = POS_W'(pos);
		send_item(it);
	endtask

	// One random item, mostly aimed at the hot profiles so that their
	// tracking state gets deep; a tenth is noise with any profile code.
	task automatic send_random_op();
		int p;
		int sh;
		int md;
		int ax;
		int roll;
		int slot;
		if ($urandom_range(0, 9) < 8)
			p = hot_prof[$urandom_range(0, HOT_COUNT - 1)];
		else
			p = $urandom_range(0, PROFILES - 1);
		split_profile(p, sh, md, ax);
		roll = $urandom_range(0, 99);
		slot = $urandom_range(0, 15);
		if (roll < 60) begin
			sample_at(sh, md, ax, aim_position(p));
		end else if (roll < 68) begin
			send_settings(sh, md, ax, $urandom_range(0, 3), resist_draw(), resist_draw());
		end else if (roll < 80) begin
			// Half the limits climb with the slot so that long band lists form.
			if ($urandom_range(0, 1) == 0)
				send_table(CMD_LIMIT, sh, md, ax, slot, slot * 7 + $urandom_range(1, 7));
			else
				send_table(CMD_LIMIT, sh, md, ax, slot, $urandom_range(0, 255));
		end else if (roll < 90) begin
			send_table(CMD_ACTION, sh, md, ax, slot, $urandom_range(0, 65535));
		end else begin
			send_item(random_item(cmd_t'(CMD_W'($urandom())), $urandom_range(0, 1),
				$urandom_range(0, 3), $urandom_range(0, 15)));
		end
	endtask

	// Holds the cmd channel idle until every owed event has been taken.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Incremental profile at the lowest profile code: zero and full
	// resistance, equal positions, both range ends and the exact thresholds.
	task automatic test_incremental_edges();
		send_table(CMD_ACTION, 0, 0, 0, 0, 0);
		send_settings(0, 0, 0, 1, 0, 0);
		// Equal to the reset reference: no step either way.
		sample_at(0, 0, 0, 0);
		sample_at(0, 0, 0, FULL_SCALE - 1);
		sample_at(0, 0, 0, FULL_SCALE - 1);
		sample_at(0, 0, 0, 0);
		// Both mode bits set: incremental takes priority over banded.
		send_settings(0, 0, 0, 3, 255, 255);
		// A move of exactly the resistance does not fire; one more does.
		sample_at(0, 0, 0, 255);
		sample_at(0, 0, 0, 256);
		sample_at(0, 0, 0, FULL_SCALE - 1);
		sample_at(0, 0, 0, FULL_SCALE - 1 - 255);
		sample_at(0, 0, 0, FULL_SCALE - 1 - 256);
	endtask

	// Banded profile at the highest profile code: band changes in both
	// directions, a band equal to the stored one, a limit past the list end,
	// a limit of exactly 100 percent and a dropped out-of-range profile.
	task automatic test_banded_walk();
		send_settings(1, 2, 8, 2, $urandom_range(0, 255), $urandom_range(0, 255));
		send_table(CMD_LIMIT, 1, 2, 8, 0, 10);
		send_table(CMD_LIMIT, 1, 2, 8, 1, 50);
		send_table(CMD_LIMIT, 1, 2, 8, NUM_BANDS - 1, 255);
		send_table(CMD_ACTION, 1, 2, 8, NUM_BANDS - 1, 16'hFFFF);
		// Band 0 matches the reset band and fires nothing.
		sample_at(1, 2, 8, 0);
		// 204 is the full-width top of the 10 percent band, so it is band 1.
		sample_at(1, 2, 8, 204);
		sample_at(1, 2, 8, FULL_SCALE - 1);
		sample_at(1, 2, 8, 203);
		sample_at(1, 3, 15, 1000);
		send_table(CMD_LIMIT, 1, 2, 8, 1, PCT_FULL);
		sample_at(1, 2, 8, 1000);
	endtask

	task automatic test_random_traffic();
		int sh;
		int md;
		int ax;
		for (int h = 0; h < HOT_COUNT; h++) begin
			hot_prof[h] = $urandom_range(0, PROFILES - 1);
			split_profile(hot_prof[h], sh, md, ax);
			send_settings(sh, md, ax, $urandom_range(1, 3), resist_draw(), resist_draw());
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				quiet_phase = ($urandom_range(0, 3) == 0);
			send_random_op();
		end
		quiet_phase = 1'b0;
	endtask

	// The sender stops mid-stream until every event is out, then resumes.
	task automatic test_drain_pause();
		repeat (20) send_random_op();
		wait_drained();
		repeat (20) send_random_op();
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	function automatic string event_text(input out_item_t e);
		return $sformatf("action=%h slot=%0d axis=%0d shift=%0d mode=%0d pos=%0d band=%0d",
			e.action_id, e.change_index, e.axis_echo, e.shift_echo, e.mode_echo,
			e.incremental_position, e.band_index);
	endfunction

	function automatic void check_event(input out_item_t got);
		out_item_t want;
		if (pending_events.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("unexpected event: %s", event_text(got));
			return;
		end
		want = pending_events.pop_front();
		if (got.action_id !== want.action_id || got.change_index !== want.change_index
			|| got.axis_echo !== want.axis_echo || got.shift_echo !== want.shift_echo
			|| got.mode_echo !== want.mode_echo
			|| got.incremental_position !== want.incremental_position
			|| got.band_index !== want.band_index) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT) begin
				$display("event differs: expected %s", event_text(want));
				$display("               actual   %s", event_text(got));
			end
		end
	endfunction

	// Receiver: draws a stall before each event, then holds ready high until
	// a transfer happens. Outputs are read right after the edge, so they are
	// the values the block presented at that edge.
	initial begin : evt_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet_phase ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				evt_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			evt_ready <= 1'b1;
			do @(posedge clk); while (evt_valid !== 1'b1);
			check_event(evt_data);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rotary_axis_step_detector: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		clear_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// The block clears its memories after reset; the first transfer simply
		// waits for cmd_ready.
		test_incremental_edges();
		test_banded_walk();
		test_random_traffic();
		test_drain_pause();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_events.size() == 0) begin
			$display("rotary_axis_step_detector: match");
		end else begin
			$display("rotary_axis_step_detector: mismatch");
		end
		$finish;
	end

endmodule
